/* rtl/mlpq_pkg.sv */
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and codes for the multilevel priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
package mlpq_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int CfgW = 11;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        payload;
    logic signed [15:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped_payload;
    logic [4:0]  level_used;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start level calc
    logic div_step;  // one restoring divide step
    logic clamp;     // clamp quotient into target level
    logic scan_load; // load scan index from candidate
    logic scan_dec;  // step scan index down
    logic rd_mem;    // issue memory read for pop
    logic commit;    // update state and present result
  } mlpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic need_div;
    logic scan_hit;
    logic scan_zero;
  } mlpq_sts_t;

endpackage
`default_nettype wire

/* rtl/mlpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mlpq_ctrl
// Sequencer: level calculation, pop scan, memory read and commit.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_ctrl #(
  parameter int DivSteps = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  output mlpq_pkg::mlpq_cmd_t       cmd,
  input  wire mlpq_pkg::mlpq_sts_t  sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CLMP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_COMM = 3'd6;
  localparam int CntW = $clog2(DivSteps + 1);

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_pop) begin
          cmd.scan_load = 1'b1;
          state_nxt     = S_SCAN;
        end else if (sts.need_div) begin
          cnt_nxt   = CntW'(DivSteps);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_CLMP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) state_nxt = S_CLMP;
      end
      S_CLMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_RD;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_zero) begin
          state_nxt = S_RD;
        end else begin
          cmd.scan_dec = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = S_COMM;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_cnt_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("divide counter ran out in divide state");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_DEC))
    else $error("accepted transaction did not start");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit)
    else $error("commit repeated");
endmodule
`default_nettype wire

/* rtl/mlpq_dp.sv */
// ----------------------------------------------------------------------------
// mlpq_dp
// Datapath: level calculation, per-level FIFO state, payload memory.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_dp #(
  parameter int LevelCount = 32,
  parameter int FifoDepth  = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire mlpq_pkg::in_item_t   in_item,
  input  wire                       cfg_we,
  input  wire [mlpq_pkg::CfgW-1:0]  cfg_data,
  input  wire mlpq_pkg::mlpq_cmd_t  cmd,
  output mlpq_pkg::mlpq_sts_t       sts,
  output logic                      out_valid,
  output mlpq_pkg::out_item_t       out_item
);
  localparam int LvW  = $clog2(LevelCount);
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int QW   = 16 + $clog2(LevelCount + 1);
  // one block of 2**PtrW slots per level, addressed as {level, pointer}
  localparam int Depth = LevelCount * (2 ** PtrW);
  localparam int CfgW = mlpq_pkg::CfgW;

  logic [CfgW-1:0] lcnt_r;
  logic            is_pop_r;
  logic [31:0]     pay_r;
  logic [15:0]     pri_r;
  logic [QW-1:0]   quo_r;     // dividend shifting into quotient
  logic [CfgW:0]   rem_r;
  logic [LvW-1:0]  lvl_r;
  logic [LvW-1:0]  cand_r;
  logic            found_r;
  logic [CntW-1:0] fill_r [LevelCount];
  logic [PtrW-1:0] head_r [LevelCount];
  logic [PtrW-1:0] tail_r [LevelCount];
  logic [31:0]     mem [Depth];
  logic [31:0]     rd_r;

  logic [CfgW-1:0] lv_eff;
  logic [CfgW-1:0] top;
  logic [CfgW:0]   rem_sh, rem_sub;
  logic [QW-1:0]   q_val;
  logic [LvW-1:0]  lvl_clamped;
  logic            full;
  logic            fill_zero;
  mlpq_pkg::out_item_t out_nxt;

  assign lv_eff = (lcnt_r == '0) ? CfgW'(1) : lcnt_r;
  assign top    = ((lv_eff < CfgW'(LevelCount)) ? lv_eff : CfgW'(LevelCount)) - 1'b1;
  assign rem_sh  = {rem_r[CfgW-1:0], quo_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, lv_eff};
  assign q_val = quo_r;
  assign lvl_clamped = pri_r[15] ? '0 :
                       (q_val > QW'(top)) ? LvW'(top) : LvW'(q_val);
  assign full      = (fill_r[lvl_r] == CntW'(FifoDepth));
  assign fill_zero = (fill_r[lvl_r] == '0);

  assign sts.is_pop    = is_pop_r;
  assign sts.need_div  = (lv_eff > CfgW'(LevelCount));
  assign sts.scan_hit  = !fill_zero;
  assign sts.scan_zero = (lvl_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= CfgW'(32);
    end else if (cfg_we) begin
      lcnt_r <= cfg_data;
    end
  end

  // level calculation: dividend is priority * LevelCount when scaling
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_pop_r <= (in_item.req_type == mlpq_pkg::REQ_POP);
      pay_r    <= in_item.payload;
      pri_r    <= in_item.priority_req;
      quo_r    <= sts.need_div ? QW'(in_item.priority_req[14:0]) * QW'(LevelCount)
                               : QW'(in_item.priority_req[14:0]);
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[CfgW]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  // target level and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (cmd.load) begin
      lvl_r <= '0;
    end else if (cmd.clamp) begin
      lvl_r <= lvl_clamped;
    end else if (cmd.scan_load) begin
      lvl_r <= cand_r;
    end else if (cmd.scan_dec) begin
      lvl_r <= lvl_r - 1'b1;
    end
  end

  // pop memory read and payload write
  always_ff @(posedge clk) begin
    if (cmd.rd_mem) begin
      rd_r    <= mem[{lvl_r, head_r[lvl_r]}];
      found_r <= !fill_zero;
    end
    if (cmd.load) found_r <= 1'b0;
    if (cmd.commit && !is_pop_r && !full) begin
      mem[{lvl_r, tail_r[lvl_r]}] <= pay_r;
    end
  end

  // result of the transaction in flight
  always_comb begin
    out_nxt            = '0;
    out_nxt.level_used = 5'(lvl_r);
    if (!is_pop_r) begin
      out_nxt.status = full ? mlpq_pkg::ST_FULL : mlpq_pkg::ST_OK;
    end else if (found_r) begin
      out_nxt.status         = mlpq_pkg::ST_OK;
      out_nxt.popped_payload = rd_r;
    end else begin
      out_nxt.status     = mlpq_pkg::ST_EMPTY;
      out_nxt.level_used = '0;
    end
  end

  // per-level FIFO control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LevelCount; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      cand_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.commit;
      if (cmd.commit) begin
        out_item <= out_nxt;
        if (!is_pop_r) begin
          if (!full) begin
            tail_r[lvl_r] <= (tail_r[lvl_r] == PtrW'(FifoDepth - 1)) ? '0 : tail_r[lvl_r] + 1'b1;
            fill_r[lvl_r] <= fill_r[lvl_r] + 1'b1;
            if (lvl_r > cand_r) cand_r <= lvl_r;
          end
        end else if (found_r) begin
          head_r[lvl_r] <= (head_r[lvl_r] == PtrW'(FifoDepth - 1)) ? '0 : head_r[lvl_r] + 1'b1;
          fill_r[lvl_r] <= fill_r[lvl_r] - 1'b1;
          if (fill_r[lvl_r] == CntW'(1)) begin
            cand_r <= (lvl_r == '0) ? '0 : lvl_r - 1'b1;
          end else begin
            cand_r <= lvl_r;
          end
        end else begin
          cand_r <= '0;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[lvl_r] <= CntW'(FifoDepth))
    else $error("fill count above depth");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == mlpq_pkg::ST_EMPTY) |-> (out_item.popped_payload == '0))
    else $error("empty pop carries data");
endmodule
`default_nettype wire

/* rtl/multilevel_priority_queue.sv */
// ----------------------------------------------------------------------------
// multilevel_priority_queue
// Priority queue with one FIFO per level; insert by priority, pop highest.
// ----------------------------------------------------------------------------
// Channel  Ports                          Handshake
// input    start, busy, in_item           accept when start && !busy
// result   out_valid, out_item            one-cycle strobe, no backpressure
// config   cfg_we, cfg_data               write when cfg_we
//
// An insert computes its level directly, or, when the configured level count
// exceeds the hardware levels, through a serial divider that yields one
// quotient bit a cycle, 16 + clog2(LEVEL_COUNT + 1) bits in all.
// A pop scans down from the candidate level, past empty levels, to a hit.
// The payload memory is one port, read in the cycle before the commit.
// Synchronous reset empties every level; stored payloads need no clearing.
// The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module multilevel_priority_queue #(
  parameter int LEVEL_COUNT = 32,
  parameter int FIFO_DEPTH  = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire mlpq_pkg::in_item_t   in_item,
  output logic                      out_valid,
  output mlpq_pkg::out_item_t       out_item,
  input  wire                       cfg_we,
  input  wire [mlpq_pkg::CfgW-1:0]  cfg_data
);
  mlpq_pkg::mlpq_cmd_t cmd;
  mlpq_pkg::mlpq_sts_t sts;

  // controller sequences each transaction
  mlpq_ctrl #(.DivSteps(16 + $clog2(LEVEL_COUNT + 1))) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  // datapath holds levels, pointers and payload memory
  mlpq_dp #(.LevelCount(LEVEL_COUNT), .FifoDepth(FIFO_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_item(out_item)
  );
endmodule
`default_nettype wire
